>>> sv/c6502_pkg.sv
// Shared types and constants for the 6502 execute block.
package c6502_pkg;

  localparam logic [7:0] FL_C = 8'h01;
  localparam logic [7:0] FL_Z = 8'h02;
  localparam logic [7:0] FL_I = 8'h04;
  localparam logic [7:0] FL_D = 8'h08;
  localparam logic [7:0] FL_B = 8'h10;
  localparam logic [7:0] FL_U = 8'h20;
  localparam logic [7:0] FL_V = 8'h40;
  localparam logic [7:0] FL_N = 8'h80;

  localparam logic [7:0]  SP_RESET     = 8'hFD;
  localparam logic [7:0]  STATUS_RESET = 8'h34;
  localparam logic [15:0] STACK_BASE   = 16'h0100;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  p;
    logic [15:0] pc;
  } regs_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  opcode;
    logic [7:0]  operand_value;
    logic [15:0] operand_address;
    logic [1:0]  instr_length;
    logic [7:0]  stack_byte_1;
    logic [7:0]  stack_byte_2;
    logic [7:0]  stack_byte_3;
    logic [15:0] vector_word;
  } item_t;

  typedef struct packed {
    logic [1:0]  count;
    logic [15:0] addr0;
    logic [7:0]  data0;
    logic [15:0] addr1;
    logic [7:0]  data1;
    logic [15:0] addr2;
    logic [7:0]  data2;
  } writes_t;

endpackage

>>> sv/c6502_alu.sv
// Combinational execution of one instruction on the register file.
module c6502_alu
  import c6502_pkg::*;
(
  input  item_t   item,
  input  regs_t   cur,
  output regs_t   nxt,
  output writes_t wr
);

  logic [7:0]  m;
  logic [15:0] pc_adv;
  logic [15:0] ret;
  logic [8:0]  sum;
  logic [7:0]  addend;
  logic [7:0]  sh;
  logic        sh_c;
  logic        bset;
  logic [7:0]  cmp_r;
  logic [7:0]  nzv;

  assign m      = item.operand_value;
  assign pc_adv = cur.pc + {14'd0, item.instr_length};
  assign ret    = pc_adv - 16'd1;

  always_comb begin
    addend = (item.opcode[7:5] == 3'b111) ? ~m : m;
    sum    = {1'b0, cur.a} + {1'b0, addend} + {8'd0, cur.p[0]};
  end

  // Shift unit: accumulator form for the 0x0A column, memory form otherwise.
  always_comb begin
    logic [7:0] v;
    v = (item.opcode[3:0] == 4'hA) ? cur.a : m;
    if (!item.opcode[6]) begin
      sh   = {v[6:0], item.opcode[5] & cur.p[0]};
      sh_c = v[7];
    end else begin
      sh   = {item.opcode[5] & cur.p[0], v[7:1]};
      sh_c = v[0];
    end
  end

  always_comb begin
    unique case (item.opcode[7:6])
      2'd0:    bset = cur.p[7];
      2'd1:    bset = cur.p[6];
      2'd2:    bset = cur.p[0];
      default: bset = cur.p[1];
    endcase
  end

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    set_nz = {v[7], p[6:2], (v == 8'd0), p[0]};
  endfunction

  always_comb begin
    logic [7:0] d;
    nxt = cur;
    wr  = '0;
    cmp_r = cur.a;
    nzv = 8'd0;
    d = 8'd0;
    if (item.mode) begin
      nxt.a  = 8'd0;
      nxt.x  = 8'd0;
      nxt.y  = 8'd0;
      nxt.sp = SP_RESET;
      nxt.pc = item.vector_word;
      nxt.p  = cur.p | FL_I | FL_B | FL_U;
    end else begin
      nxt.pc = pc_adv;
      if (item.opcode[4:0] == 5'h10) begin
        if (bset == item.opcode[5])
          nxt.pc = pc_adv + {{8{m[7]}}, m};
      end else begin
        unique case (item.opcode)
          8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D: begin
            nxt.a = cur.a | m; nxt.p = set_nz(cur.p, nxt.a);
          end
          8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: begin
            nxt.a = cur.a & m; nxt.p = set_nz(cur.p, nxt.a);
          end
          8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h55, 8'h59, 8'h5D: begin
            nxt.a = cur.a ^ m; nxt.p = set_nz(cur.p, nxt.a);
          end
          8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D,
          8'hE1, 8'hE5, 8'hE9, 8'hED, 8'hF1, 8'hF5, 8'hF9, 8'hFD: begin
            nxt.a = sum[7:0];
            nzv = set_nz(cur.p, sum[7:0]);
            nxt.p = {nzv[7], (~(cur.a[7] ^ addend[7])) & (cur.a[7] ^ sum[7]),
                     nzv[5:1], sum[8]};
          end
          8'h81, 8'h85, 8'h8D, 8'h91, 8'h95, 8'h99, 8'h9D: begin
            wr.count = 2'd1; wr.addr0 = item.operand_address; wr.data0 = cur.a;
          end
          8'h86, 8'h8E, 8'h96: begin
            wr.count = 2'd1; wr.addr0 = item.operand_address; wr.data0 = cur.x;
          end
          8'h84, 8'h8C, 8'h94: begin
            wr.count = 2'd1; wr.addr0 = item.operand_address; wr.data0 = cur.y;
          end
          8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB5, 8'hB9, 8'hBD: begin
            nxt.a = m; nxt.p = set_nz(cur.p, m);
          end
          8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: begin
            nxt.x = m; nxt.p = set_nz(cur.p, m);
          end
          8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: begin
            nxt.y = m; nxt.p = set_nz(cur.p, m);
          end
          8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD5, 8'hD9, 8'hDD,
          8'hE0, 8'hE4, 8'hEC, 8'hC0, 8'hC4, 8'hCC: begin
            if (item.opcode[1:0] == 2'b01) cmp_r = cur.a;
            else if (item.opcode[5]) cmp_r = cur.x;
            else cmp_r = cur.y;
            d = cmp_r - m;
            nzv = set_nz(cur.p, d);
            nxt.p = {nzv[7:1], (cmp_r >= m)};
          end
          8'h0A, 8'h2A, 8'h4A, 8'h6A: begin
            nxt.a = sh; nzv = set_nz(cur.p, sh); nxt.p = {nzv[7:1], sh_c};
          end
          8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h36, 8'h3E,
          8'h46, 8'h4E, 8'h56, 8'h5E, 8'h66, 8'h6E, 8'h76, 8'h7E: begin
            nzv = set_nz(cur.p, sh); nxt.p = {nzv[7:1], sh_c};
            wr.count = 2'd1; wr.addr0 = item.operand_address; wr.data0 = sh;
          end
          8'hC6, 8'hCE, 8'hD6, 8'hDE: begin
            d = m - 8'd1; nxt.p = set_nz(cur.p, d);
            wr.count = 2'd1; wr.addr0 = item.operand_address; wr.data0 = d;
          end
          8'hE6, 8'hEE, 8'hF6, 8'hFE: begin
            d = m + 8'd1; nxt.p = set_nz(cur.p, d);
            wr.count = 2'd1; wr.addr0 = item.operand_address; wr.data0 = d;
          end
          8'h24, 8'h2C: begin
            nxt.p = {m[7], m[6], cur.p[5:2], ((m & cur.a) == 8'd0), cur.p[0]};
          end
          8'h4C, 8'h6C: nxt.pc = item.operand_address;
          8'h20: begin
            wr.count = 2'd2;
            wr.addr0 = STACK_BASE | {8'd0, cur.sp};         wr.data0 = ret[15:8];
            wr.addr1 = STACK_BASE | {8'd0, cur.sp - 8'd1};  wr.data1 = ret[7:0];
            nxt.sp = cur.sp - 8'd2;
            nxt.pc = item.operand_address;
          end
          8'h00: begin
            wr.count = 2'd3;
            wr.addr0 = STACK_BASE | {8'd0, cur.sp};         wr.data0 = pc_adv[15:8];
            wr.addr1 = STACK_BASE | {8'd0, cur.sp - 8'd1};  wr.data1 = pc_adv[7:0];
            wr.addr2 = STACK_BASE | {8'd0, cur.sp - 8'd2};  wr.data2 = cur.p | FL_B | FL_U;
            nxt.sp = cur.sp - 8'd3;
            nxt.p  = cur.p | FL_I | FL_B | FL_U;
            nxt.pc = item.vector_word;
          end
          8'h40: begin
            nxt.p  = item.stack_byte_1 | FL_B | FL_U;
            nxt.pc = {item.stack_byte_3, item.stack_byte_2};
            nxt.sp = cur.sp + 8'd3;
          end
          8'h60: begin
            nxt.pc = {item.stack_byte_2, item.stack_byte_1} + 16'd1;
            nxt.sp = cur.sp + 8'd2;
          end
          8'h08, 8'h48: begin
            wr.count = 2'd1;
            wr.addr0 = STACK_BASE | {8'd0, cur.sp};
            wr.data0 = item.opcode[6] ? cur.a : (cur.p | FL_B | FL_U);
            nxt.sp = cur.sp - 8'd1;
          end
          8'h28: begin
            nxt.p = item.stack_byte_1 | FL_B | FL_U; nxt.sp = cur.sp + 8'd1;
          end
          8'h68: begin
            nxt.a = item.stack_byte_1; nxt.p = set_nz(cur.p, item.stack_byte_1);
            nxt.sp = cur.sp + 8'd1;
          end
          8'h18: nxt.p = cur.p & ~FL_C;
          8'h38: nxt.p = cur.p | FL_C;
          8'h58: nxt.p = cur.p & ~FL_I;
          8'h78: nxt.p = cur.p | FL_I;
          8'hB8: nxt.p = cur.p & ~FL_V;
          8'hD8: nxt.p = cur.p & ~FL_D;
          8'hF8: nxt.p = cur.p | FL_D;
          8'h88: begin nxt.y = cur.y - 8'd1; nxt.p = set_nz(cur.p, nxt.y); end
          8'hC8: begin nxt.y = cur.y + 8'd1; nxt.p = set_nz(cur.p, nxt.y); end
          8'hCA: begin nxt.x = cur.x - 8'd1; nxt.p = set_nz(cur.p, nxt.x); end
          8'hE8: begin nxt.x = cur.x + 8'd1; nxt.p = set_nz(cur.p, nxt.x); end
          8'h8A: begin nxt.a = cur.x; nxt.p = set_nz(cur.p, cur.x); end
          8'h98: begin nxt.a = cur.y; nxt.p = set_nz(cur.p, cur.y); end
          8'hA8: begin nxt.y = cur.a; nxt.p = set_nz(cur.p, cur.a); end
          8'hAA: begin nxt.x = cur.a; nxt.p = set_nz(cur.p, cur.a); end
          8'hBA: begin nxt.x = cur.sp; nxt.p = set_nz(cur.p, cur.sp); end
          8'h9A: nxt.sp = cur.x;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> sv/cpu_6502_instruction_execute.sv
// Top level of the 6502 execute block: input register, ALU and result sequencer.
// One instruction is taken per beat on s_axis; its result goes out as one beat on
// m_axis, or one beat per memory write when it writes (BRK three, JSR two).
// An instruction with at most one write streams at one item per cycle while
// m_axis_tready is high; the result register's write-beat counter then moves
// one output beat per cycle. Every beat of an item shows the same register view.
module cpu_6502_instruction_execute
  import c6502_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode, opcode, operand_value, operand_address, instr_length,
  // stack_byte_1, stack_byte_2, stack_byte_3, vector_word; zero pad to 80 bits
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // write_valid, write_address, write_data, acc_out, x_out, y_out, sp_out,
  // status_out, pc_out; zero pad to 88 bits
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  regs_t   regs;
  regs_t   regs_next;
  item_t   item;
  writes_t wr;
  writes_t held;
  regs_t   view;
  logic [1:0] idx;
  logic       pend;

  assign item.mode            = s_axis_tdata[0];
  assign item.opcode          = s_axis_tdata[8:1];
  assign item.operand_value   = s_axis_tdata[16:9];
  assign item.operand_address = s_axis_tdata[32:17];
  assign item.instr_length    = s_axis_tdata[34:33];
  assign item.stack_byte_1    = s_axis_tdata[42:35];
  assign item.stack_byte_2    = s_axis_tdata[50:43];
  assign item.stack_byte_3    = s_axis_tdata[58:51];
  assign item.vector_word     = s_axis_tdata[74:59];

  c6502_alu u_alu (
    .item(item),
    .cur (regs),
    .nxt (regs_next),
    .wr  (wr)
  );

  logic is_last;
  assign is_last = (held.count == 2'd0) || ({1'b0, idx} + 3'd1 >= {1'b0, held.count});
  assign s_axis_tready = !pend || (m_axis_tready && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{a: 8'd0, x: 8'd0, y: 8'd0, sp: SP_RESET, p: STATUS_RESET, pc: 16'd0};
      pend <= 1'b0;
      idx  <= 2'd0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        regs <= regs_next;
        held <= wr;
        view <= regs_next;
        pend <= 1'b1;
        idx  <= 2'd0;
      end else if (pend && m_axis_tready) begin
        if (is_last) pend <= 1'b0;
        else idx <= idx + 2'd1;
      end
    end
  end

  logic        wv;
  logic [15:0] wa;
  logic [7:0]  wd;
  always_comb begin
    wv = held.count != 2'd0;
    unique case (idx)
      2'd0:    begin wa = held.addr0; wd = held.data0; end
      2'd1:    begin wa = held.addr1; wd = held.data1; end
      default: begin wa = held.addr2; wd = held.data2; end
    endcase
    if (!wv) begin
      wa = 16'd0;
      wd = 8'd0;
    end
  end

  assign m_axis_tvalid = pend;
  assign m_axis_tlast  = is_last;
  assign m_axis_tdata  = {7'd0, view.pc, view.p, view.sp, view.y, view.x, view.a,
                          wd, wa, wv};

endmodule

>>> test/tb_cpu_6502_instruction_execute.sv
// Self-checking testbench for the 6502 execute block over its stream ports.
module tb_cpu_6502_instruction_execute;
  import c6502_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [7:0] {
    OP_BRK = 8'h00, OP_PHP = 8'h08, OP_JSR = 8'h20, OP_PLP = 8'h28, OP_RTI = 8'h40,
    OP_PHA = 8'h48, OP_JMP = 8'h4C, OP_RTS = 8'h60, OP_PLA = 8'h68, OP_STA = 8'h8D,
    OP_LDA = 8'hA9, OP_LDX = 8'hA2, OP_LDY = 8'hA0, OP_ADC = 8'h69, OP_SBC = 8'hE9,
    OP_TXS = 8'h9A, OP_SEC = 8'h38, OP_CLC = 8'h18, OP_ASLA = 8'h0A, OP_RORA = 8'h6A,
    OP_INC = 8'hEE, OP_DEC = 8'hCE, OP_BIT = 8'h2C, OP_CMP = 8'hC9, OP_BNE = 8'hD0,
    OP_SED = 8'hF8
  } opcode_e;

  typedef struct packed {
    logic        wv;
    logic [15:0] wa;
    logic [7:0]  wd;
    logic        last;
    regs_t       r;
  } beat_t;

  // Predicts the beats of each instruction and checks those the block emits.
  class exec_scoreboard;
    regs_t r;
    beat_t pending[$];
    int errors;
    int beats_seen;

    function new();
      r = '{a: 8'h00, x: 8'h00, y: 8'h00, sp: SP_RESET, p: STATUS_RESET, pc: 16'h0000};
      errors = 0;
      beats_seen = 0;
    endfunction

    function void set_nz(logic [7:0] v);
      r.p[7] = v[7];
      r.p[1] = (v == 8'h00);
    endfunction

    function logic [7:0] shift(logic [1:0] kind, logic [7:0] v);
      logic [7:0] res;
      logic cin;
      cin = r.p[0];
      if (kind < 2) begin
        res = {v[6:0], (kind == 1) ? cin : 1'b0};
        r.p[0] = v[7];
      end else begin
        res = {(kind == 3) ? cin : 1'b0, v[7:1]};
        r.p[0] = v[0];
      end
      set_nz(res);
      return res;
    endfunction

    function void add(logic [7:0] m);
      logic [8:0] sum;
      sum = {1'b0, r.a} + {1'b0, m} + r.p[0];
      r.p[0] = sum[8];
      r.p[6] = ~(r.a[7] ^ m[7]) & (r.a[7] ^ sum[7]);
      r.a = sum[7:0];
      set_nz(r.a);
    endfunction

    function void cmp(logic [7:0] rv, logic [7:0] m);
      logic [7:0] d;
      d = rv - m;
      r.p[0] = (rv >= m);
      set_nz(d);
    endfunction

    function void note_input(item_t it);
      logic [15:0] wa[3];
      logic [7:0] wd[3];
      logic [15:0] ret;
      logic [7:0] m, t;
      logic tkn;
      int n, cnt;
      beat_t b;
      n = 0;
      m = it.operand_value;
      if (it.mode) begin
        r.a = 0; r.x = 0; r.y = 0; r.pc = it.vector_word; r.sp = SP_RESET;
        r.p = r.p | FL_I | FL_B | FL_U;
      end else begin
        r.pc = r.pc + it.instr_length;
        if (it.opcode[4:0] == 5'h10) begin
          case (it.opcode[7:6])
            2'd0: tkn = r.p[7];
            2'd1: tkn = r.p[6];
            2'd2: tkn = r.p[0];
            default: tkn = r.p[1];
          endcase
          if (tkn == it.opcode[5]) r.pc = r.pc + {{8{m[7]}}, m};
        end else begin
          case (it.opcode)
            8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D: begin
              r.a = r.a | m; set_nz(r.a); end
            8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: begin
              r.a = r.a & m; set_nz(r.a); end
            8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h55, 8'h59, 8'h5D: begin
              r.a = r.a ^ m; set_nz(r.a); end
            8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D: add(m);
            8'hE1, 8'hE5, 8'hE9, 8'hED, 8'hF1, 8'hF5, 8'hF9, 8'hFD: add(~m);
            8'h81, 8'h85, 8'h8D, 8'h91, 8'h95, 8'h99, 8'h9D: begin
              wa[n] = it.operand_address; wd[n] = r.a; n++; end
            8'h86, 8'h8E, 8'h96: begin
              wa[n] = it.operand_address; wd[n] = r.x; n++; end
            8'h84, 8'h8C, 8'h94: begin
              wa[n] = it.operand_address; wd[n] = r.y; n++; end
            8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB5, 8'hB9, 8'hBD: begin
              r.a = m; set_nz(m); end
            8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: begin r.x = m; set_nz(m); end
            8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: begin r.y = m; set_nz(m); end
            8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD5, 8'hD9, 8'hDD: cmp(r.a, m);
            8'hE0, 8'hE4, 8'hEC: cmp(r.x, m);
            8'hC0, 8'hC4, 8'hCC: cmp(r.y, m);
            8'h0A, 8'h2A, 8'h4A, 8'h6A: r.a = shift(it.opcode[6:5], r.a);
            8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h36, 8'h3E,
            8'h46, 8'h4E, 8'h56, 8'h5E, 8'h66, 8'h6E, 8'h76, 8'h7E: begin
              wa[n] = it.operand_address; wd[n] = shift(it.opcode[6:5], m); n++; end
            8'hC6, 8'hCE, 8'hD6, 8'hDE: begin
              t = m - 8'd1; set_nz(t); wa[n] = it.operand_address; wd[n] = t; n++; end
            8'hE6, 8'hEE, 8'hF6, 8'hFE: begin
              t = m + 8'd1; set_nz(t); wa[n] = it.operand_address; wd[n] = t; n++; end
            8'h24, 8'h2C: begin
              r.p[7] = m[7]; r.p[6] = m[6]; r.p[1] = ((m & r.a) == 0); end
            8'h4C, 8'h6C: r.pc = it.operand_address;
            OP_JSR: begin
              ret = r.pc - 16'd1;
              wa[n] = STACK_BASE | r.sp; wd[n] = ret[15:8]; n++; r.sp--;
              wa[n] = STACK_BASE | r.sp; wd[n] = ret[7:0]; n++; r.sp--;
              r.pc = it.operand_address;
            end
            OP_BRK: begin
              wa[n] = STACK_BASE | r.sp; wd[n] = r.pc[15:8]; n++; r.sp--;
              wa[n] = STACK_BASE | r.sp; wd[n] = r.pc[7:0]; n++; r.sp--;
              wa[n] = STACK_BASE | r.sp; wd[n] = r.p | FL_B | FL_U; n++; r.sp--;
              r.p = r.p | FL_I | FL_B | FL_U;
              r.pc = it.vector_word;
            end
            OP_RTI: begin
              r.p = it.stack_byte_1 | FL_B | FL_U;
              r.pc = {it.stack_byte_3, it.stack_byte_2};
              r.sp = r.sp + 8'd3;
            end
            OP_RTS: begin
              r.pc = {it.stack_byte_2, it.stack_byte_1} + 16'd1;
              r.sp = r.sp + 8'd2;
            end
            OP_PHP: begin
              wa[n] = STACK_BASE | r.sp; wd[n] = r.p | FL_B | FL_U; n++; r.sp--; end
            OP_PHA: begin wa[n] = STACK_BASE | r.sp; wd[n] = r.a; n++; r.sp--; end
            OP_PLP: begin r.p = it.stack_byte_1 | FL_B | FL_U; r.sp++; end
            OP_PLA: begin r.a = it.stack_byte_1; set_nz(r.a); r.sp++; end
            8'h18: r.p[0] = 1'b0;
            8'h38: r.p[0] = 1'b1;
            8'h58: r.p[2] = 1'b0;
            8'h78: r.p[2] = 1'b1;
            8'hB8: r.p[6] = 1'b0;
            8'hD8: r.p[3] = 1'b0;
            8'hF8: r.p[3] = 1'b1;
            8'h88: begin r.y--; set_nz(r.y); end
            8'hC8: begin r.y++; set_nz(r.y); end
            8'hCA: begin r.x--; set_nz(r.x); end
            8'hE8: begin r.x++; set_nz(r.x); end
            8'h8A: begin r.a = r.x; set_nz(r.a); end
            8'h98: begin r.a = r.y; set_nz(r.a); end
            8'hA8: begin r.y = r.a; set_nz(r.y); end
            8'hAA: begin r.x = r.a; set_nz(r.x); end
            8'hBA: begin r.x = r.sp; set_nz(r.x); end
            OP_TXS: r.sp = r.x;
            default: ;
          endcase
        end
      end
      cnt = (n > 0) ? n : 1;
      for (int k = 0; k < cnt; k++) begin
        b.wv = (k < n);
        b.wa = (k < n) ? wa[k] : 16'h0000;
        b.wd = (k < n) ? wd[k] : 8'h00;
        b.last = (k == cnt - 1);
        b.r = r;
        pending.push_back(b);
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t e;
      beats_seen++;
      if (pending.size() == 0) begin
        $error("unexpected result beat %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.wv !== e.wv) begin $error("write_valid exp %h got %h", e.wv, got.wv); errors++; end
      if (got.wa !== e.wa) begin $error("write_address exp %h got %h", e.wa, got.wa); errors++; end
      if (got.wd !== e.wd) begin $error("write_data exp %h got %h", e.wd, got.wd); errors++; end
      if (got.last !== e.last) begin $error("last exp %h got %h", e.last, got.last); errors++; end
      if (got.r.a !== e.r.a) begin $error("acc_out exp %h got %h", e.r.a, got.r.a); errors++; end
      if (got.r.x !== e.r.x) begin $error("x_out exp %h got %h", e.r.x, got.r.x); errors++; end
      if (got.r.y !== e.r.y) begin $error("y_out exp %h got %h", e.r.y, got.r.y); errors++; end
      if (got.r.sp !== e.r.sp) begin $error("sp_out exp %h got %h", e.r.sp, got.r.sp); errors++; end
      if (got.r.p !== e.r.p) begin
        $error("status_out exp %h got %h", e.r.p, got.r.p); errors++; end
      if (got.r.pc !== e.r.pc) begin $error("pc_out exp %h got %h", e.r.pc, got.r.pc); errors++; end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tlast;

  exec_scoreboard sb;
  int cycles;
  int items_sent;
  bit quiet;

  cpu_6502_instruction_execute DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [79:0] pack_item(item_t it);
    return {5'd0, it.vector_word, it.stack_byte_3, it.stack_byte_2, it.stack_byte_1,
            it.instr_length, it.operand_address, it.operand_value, it.opcode, it.mode};
  endfunction

  // Output side: random stall bursts, and each accepted beat is checked.
  initial begin
    int stall;
    beat_t got;
    m_axis_tready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.wv = m_axis_tdata[0];
        got.wa = m_axis_tdata[16:1];
        got.wd = m_axis_tdata[24:17];
        got.r.a = m_axis_tdata[32:25];
        got.r.x = m_axis_tdata[40:33];
        got.r.y = m_axis_tdata[48:41];
        got.r.sp = m_axis_tdata[56:49];
        got.r.p = m_axis_tdata[64:57];
        got.r.pc = m_axis_tdata[80:65];
        got.last = m_axis_tlast;
        sb.check_beat(got);
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 18) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("tb_cpu_6502_instruction_execute: errors");
        $finish;
      end
    end
  end

  // The valid line stays high across back-to-back beats; it drops only for an
  // idle burst or when the caller stops sending.
  task automatic send_item(item_t it);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pack_item(it);
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic send_op(logic [7:0] op, logic [7:0] m, logic [15:0] ea = 16'h1234,
                         logic [1:0] len = 2'd2);
    item_t it;
    it = '{mode: 1'b0, opcode: op, operand_value: m, operand_address: ea,
           instr_length: len, stack_byte_1: 8'hA5, stack_byte_2: 8'h5A,
           stack_byte_3: 8'hC3, vector_word: 16'hBEEF};
    send_item(it);
  endtask

  function automatic item_t rand_item();
    item_t it;
    it.mode = ($urandom_range(0, 40) == 0);
    it.opcode = 8'($urandom_range(0, 255));
    it.operand_value = 8'($urandom_range(0, 255));
    it.operand_address = 16'($urandom_range(0, 65535));
    it.instr_length = 2'($urandom_range(0, 3));
    it.stack_byte_1 = 8'($urandom_range(0, 255));
    it.stack_byte_2 = 8'($urandom_range(0, 255));
    it.stack_byte_3 = 8'($urandom_range(0, 255));
    it.vector_word = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  initial begin
    item_t it;
    sb = new();
    quiet = 1'b0;
    items_sent = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Power-on with a vector, then the special cases by name.
    it = '{mode: 1'b1, opcode: 8'hFF, operand_value: 8'hFF, operand_address: 16'hFFFF,
           instr_length: 2'd3, stack_byte_1: 8'hFF, stack_byte_2: 8'hFF,
           stack_byte_3: 8'hFF, vector_word: 16'hFFFC};
    send_item(it);
    send_op(OP_LDA, 8'h80);
    send_op(OP_ADC, 8'h80);
    send_op(OP_SBC, 8'h01);
    send_op(OP_CMP, 8'h00);
    send_op(OP_SEC, 8'h00, 16'h0, 2'd1);
    send_op(OP_RORA, 8'h00, 16'h0, 2'd1);
    send_op(OP_ASLA, 8'h00, 16'h0, 2'd1);
    send_op(OP_STA, 8'h00, 16'hFFFF, 2'd3);
    send_op(OP_INC, 8'hFF, 16'h0000, 2'd3);
    send_op(OP_DEC, 8'h00, 16'h8000, 2'd3);
    send_op(OP_BIT, 8'hC0, 16'h0010, 2'd3);
    send_op(OP_BNE, 8'h80);
    send_op(OP_BNE, 8'h7F);
    send_op(OP_SED, 8'h00, 16'h0, 2'd1);
    send_op(OP_JSR, 8'h00, 16'hC000, 2'd3);
    send_op(OP_RTS, 8'h00, 16'h0, 2'd1);
    send_op(OP_PHP, 8'h00, 16'h0, 2'd1);
    send_op(OP_PHA, 8'h00, 16'h0, 2'd1);
    send_op(OP_PLP, 8'h00, 16'h0, 2'd1);
    send_op(OP_PLA, 8'h00, 16'h0, 2'd1);
    send_op(OP_LDX, 8'h00);
    send_op(OP_TXS, 8'h00, 16'h0, 2'd1);
    send_op(OP_BRK, 8'h00, 16'h0, 2'd0);
    send_op(OP_RTI, 8'h00, 16'h0, 2'd1);
    send_op(OP_JMP, 8'h00, 16'hFFFF, 2'd3);
    send_op(8'h02, 8'h00, 16'h0, 2'd1);

    // Hold off until the block has drained.
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);

    for (int i = 0; i < 320; i++) begin
      if (i == 260) quiet = 1'b1;
      send_item(rand_item());
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Ran %0d instructions, all opcodes at random plus power-on, stack and branch cases;",
             items_sent);
    $display("checked %0d result beats.", sb.beats_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_cpu_6502_instruction_execute: clean");
    end else begin
      $display("tb_cpu_6502_instruction_execute: errors");
    end
    $finish;
  end

endmodule
